// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the gene table builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");

// Checks that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: sequence");

`endif

// ===== rtl/core/gtn_pkg.sv =====
// Package with the request, response and table entry types of the gene table builder.
`timescale 1ns / 1ps

package gtn_pkg;

   localparam int RAW_W   = 16;
   localparam int IDX_W   = 8;
   localparam int FAN_W   = 8;
   localparam int KIND_W  = 2;
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 6;
   localparam int TOTAL_W = 7;
   localparam int MOD_W   = 9;
   localparam int REQ_W   = 56;
   localparam int RSP_W   = 72;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_INPUT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INTERNAL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OUTPUT   = 2'd2;

   localparam logic REG_LIMIT = 1'b0;

   localparam logic [MOD_W-1:0] LIMIT_RESET = 9'd8;
   localparam logic [MOD_W-1:0] LIMIT_MAX   = 9'd256;
   localparam logic [FAN_W-1:0] FAN_MAX     = 8'hFF;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  index;
      logic [FAN_W-1:0]  fan_in;
      logic [FAN_W-1:0]  fan_out;
   } entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0] read_slot;
      logic [RAW_W-1:0]  weight_raw;
      logic [RAW_W-1:0]  sink_raw;
      logic              sink_is_output;
      logic [RAW_W-1:0]  source_raw;
      logic              source_is_input;
   } req_type;

   typedef struct packed {
      logic                pad;
      logic                table_full;
      logic [TOTAL_W-1:0]  neuron_total;
      logic [FAN_W-1:0]    entry_fan_out;
      logic [FAN_W-1:0]    entry_fan_in;
      logic [IDX_W-1:0]    entry_index;
      logic [KIND_W-1:0]   entry_kind;
      logic                entry_valid;
      logic signed [15:0]  link_weight;
      logic [IDX_W-1:0]    dst_index;
      logic [KIND_W-1:0]   dst_kind;
      logic [IDX_W-1:0]    src_index;
      logic [KIND_W-1:0]   src_kind;
   } rsp_type;

   function automatic logic [FAN_W-1:0] sat_inc(input logic [FAN_W-1:0] v);
      return (v == FAN_MAX) ? v : v + 8'd1;
   endfunction

endpackage

// ===== rtl/core/gene_to_neuron_table_builder.sv =====
// Top level of the gene table builder: sequencer, remainder unit and neuron table.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each request carries one gene or a table command and yields one response. An add-gene
// request passes both end ids one after the other through a single restoring remainder
// unit that retires one bit a cycle. The table is then scanned one entry a cycle through
// its single read port, after which the read pipeline drains, and up to two entries are
// written back. A self loop writes back only one entry, and a gene that finds the table
// full writes none. Read, clear and no-operation requests go from idle straight to the
// finishing step. The block takes a new request only while its sequencer is idle, but it
// may do so while the previous response is still waiting to be taken; the sequencer then
// holds in its last step until that response has gone. The table needs no clearing after
// reset, so requests are taken as soon as reset ends.
module gene_to_neuron_table_builder #(
   parameter int TABLE_DEPTH       = 64,
   parameter int INPUT_CLASS_SIZE  = 32,
   parameter int OUTPUT_CLASS_SIZE = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // opcode
   input  logic [gtn_pkg::OP_W-1:0]      req_tuser,
   // source_is_input, source_raw, sink_is_output, sink_raw, weight_raw, read_slot
   input  logic [gtn_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // src_kind, src_index, dst_kind, dst_index, link_weight, entry_valid, entry_kind,
   // entry_index, entry_fan_in, entry_fan_out, neuron_total, table_full, zero pad
   output logic [gtn_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gtn_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [gtn_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [gtn_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   import gtn_pkg::*;

   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int UW  = $clog2(TABLE_DEPTH + 1);
   localparam int UWX = UW + 1;

   localparam logic [MOD_W-1:0] IN_MOD  = MOD_W'(INPUT_CLASS_SIZE);
   localparam logic [MOD_W-1:0] OUT_MOD = MOD_W'(OUTPUT_CLASS_SIZE);
   localparam logic [3:0]       DIV_LAST = 4'(RAW_W - 1);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MOD_SRC = 4'd1;
   localparam logic [3:0] ST_MOD_DST = 4'd2;
   localparam logic [3:0] ST_SCAN    = 4'd3;
   localparam logic [3:0] ST_DECIDE  = 4'd4;
   localparam logic [3:0] ST_WR_SRC  = 4'd5;
   localparam logic [3:0] ST_WR_DST  = 4'd6;
   localparam logic [3:0] ST_FINISH  = 4'd7;

   req_type req;

   logic [3:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic              src_in_ff, src_in_in;
   logic              dst_out_ff, dst_out_in;
   logic [RAW_W-1:0]  sink_raw_ff, sink_raw_in;
   logic [RAW_W-1:0]  weight_ff, weight_in;
   logic              hit_ff, hit_in;
   logic              full_ff, full_in;
   logic [MOD_W-1:0]  limit_ff, limit_in;
   logic [UW-1:0]     used_ff, used_in;

   logic [RAW_W-1:0]  div_num_ff, div_num_in;
   logic [IDX_W-1:0]  div_rem_ff, div_rem_in;
   logic [MOD_W-1:0]  div_mod_ff, div_mod_in;
   logic [3:0]        div_cnt_ff, div_cnt_in;
   logic [MOD_W-1:0]  div_trial;
   logic [IDX_W-1:0]  div_next;

   logic [IDX_W-1:0]  si_ff, si_in;
   logic [IDX_W-1:0]  di_ff, di_in;

   logic [UW-1:0]     scan_cnt_ff, scan_cnt_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic              s_found_ff, s_found_in;
   logic              d_found_ff, d_found_in;
   logic [AW-1:0]     s_idx_ff, s_idx_in;
   logic [AW-1:0]     d_idx_ff, d_idx_in;
   entry_type         s_data_ff, s_data_in;
   entry_type         d_data_ff, d_data_in;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type           rsp_ff, rsp_in;

   entry_type         neuron_mem [TABLE_DEPTH];
   entry_type         rd_data_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_data;

   logic [MOD_W-1:0]  lim_eff;
   logic [KIND_W-1:0] sk;
   logic [KIND_W-1:0] dk;
   logic              same;
   logic [UWX-1:0]    need;
   logic              csr_write;

   assign req        = req_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_LIMIT) ? CSR_DW'(limit_ff) : '0;

   assign lim_eff = (limit_ff == '0) ? 9'd1 : ((limit_ff > LIMIT_MAX) ? LIMIT_MAX : limit_ff);
   assign sk      = src_in_ff ? KIND_INPUT : KIND_INTERNAL;
   assign dk      = dst_out_ff ? KIND_OUTPUT : KIND_INTERNAL;
   assign same    = !src_in_ff && !dst_out_ff && (si_ff == di_ff);
   assign need    = UWX'(!s_found_ff) + UWX'(!d_found_ff && !same);

   assign div_trial = {div_rem_ff, div_num_ff[RAW_W-1]};
   assign div_next  = (div_trial >= div_mod_ff) ? IDX_W'(div_trial - div_mod_ff)
                                                : div_trial[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      src_in_in     = src_in_ff;
      dst_out_in    = dst_out_ff;
      sink_raw_in   = sink_raw_ff;
      weight_in     = weight_ff;
      hit_in        = hit_ff;
      full_in       = full_ff;
      limit_in      = limit_ff;
      used_in       = used_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_mod_in    = div_mod_ff;
      div_cnt_in    = div_cnt_ff;
      si_in         = si_ff;
      di_in         = di_ff;
      scan_cnt_in   = scan_cnt_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      s_found_in    = s_found_ff;
      d_found_in    = d_found_ff;
      s_idx_in      = s_idx_ff;
      d_idx_in      = d_idx_ff;
      s_data_in     = s_data_ff;
      d_data_in     = d_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_cnt_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = used_ff[AW-1:0];
      wr_data       = '0;

      if (csr_write && (csr_paddr[2] == REG_LIMIT)) begin
         limit_in = csr_pwdata[MOD_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in       = req_tuser;
               src_in_in   = req.source_is_input;
               dst_out_in  = req.sink_is_output;
               sink_raw_in = req.sink_raw;
               weight_in   = req.weight_raw;
               full_in     = 1'b0;
               hit_in      = {2'b00, req.read_slot} < IDX_W'(used_ff);
               state_in    = ST_FINISH;
               case (req_tuser)
                  OP_ADD: begin
                     div_num_in = req.source_raw;
                     div_rem_in = '0;
                     div_cnt_in = '0;
                     div_mod_in = req.source_is_input ? IN_MOD : lim_eff;
                     state_in   = ST_MOD_SRC;
                  end
                  OP_READ: begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(req.read_slot);
                  end
                  OP_CLEAR: begin
                     used_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOD_SRC, ST_MOD_DST: begin
            div_num_in = {div_num_ff[RAW_W-2:0], 1'b0};
            div_rem_in = div_next;
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == DIV_LAST) begin
               if (state_ff == ST_MOD_SRC) begin
                  si_in      = div_next;
                  div_num_in = sink_raw_ff;
                  div_rem_in = '0;
                  div_mod_in = dst_out_ff ? OUT_MOD : lim_eff;
                  state_in   = ST_MOD_DST;
               end else begin
                  di_in       = div_next;
                  scan_cnt_in = '0;
                  s_found_in  = 1'b0;
                  d_found_in  = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff < used_ff) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_cnt_ff[AW-1:0];
               scan_cnt_in  = scan_cnt_ff + 1'b1;
            end else if (!cmp_valid_ff) begin
               state_in = ST_DECIDE;
            end
            if (cmp_valid_ff) begin
               if (rd_data_ff.kind == sk && rd_data_ff.index == si_ff) begin
                  s_found_in = 1'b1;
                  s_idx_in   = cmp_idx_ff;
                  s_data_in  = rd_data_ff;
               end
               if (rd_data_ff.kind == dk && rd_data_ff.index == di_ff) begin
                  d_found_in = 1'b1;
                  d_idx_in   = cmp_idx_ff;
                  d_data_in  = rd_data_ff;
               end
            end
         end
         ST_DECIDE: begin
            if (UWX'(used_ff) + need > UWX'(TABLE_DEPTH)) begin
               full_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_WR_SRC;
            end
         end
         ST_WR_SRC: begin
            wr_en = 1'b1;
            if (s_found_ff) begin
               wr_addr         = s_idx_ff;
               wr_data         = s_data_ff;
               wr_data.fan_out = sat_inc(s_data_ff.fan_out);
               if (same) begin
                  wr_data.fan_in = sat_inc(s_data_ff.fan_in);
               end
            end else begin
               wr_data.kind    = sk;
               wr_data.index   = si_ff;
               wr_data.fan_in  = same ? 8'd1 : 8'd0;
               wr_data.fan_out = 8'd1;
               used_in         = used_ff + 1'b1;
            end
            state_in = same ? ST_FINISH : ST_WR_DST;
         end
         ST_WR_DST: begin
            wr_en = 1'b1;
            if (d_found_ff) begin
               wr_addr        = d_idx_ff;
               wr_data        = d_data_ff;
               wr_data.fan_in = sat_inc(d_data_ff.fan_in);
            end else begin
               wr_data.kind    = dk;
               wr_data.index   = di_ff;
               wr_data.fan_in  = 8'd1;
               wr_data.fan_out = 8'd0;
               used_in         = used_ff + 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_in              = '0;
               rsp_in.neuron_total = TOTAL_W'(used_ff);
               if (op_ff == OP_ADD) begin
                  rsp_in.src_kind    = sk;
                  rsp_in.src_index   = si_ff;
                  rsp_in.dst_kind    = dk;
                  rsp_in.dst_index   = di_ff;
                  rsp_in.link_weight = {~weight_ff[RAW_W-1], weight_ff[RAW_W-2:0]};
                  rsp_in.table_full  = full_ff;
               end
               if (op_ff == OP_READ && hit_ff) begin
                  rsp_in.entry_valid   = 1'b1;
                  rsp_in.entry_kind    = rd_data_ff.kind;
                  rsp_in.entry_index   = rd_data_ff.index;
                  rsp_in.entry_fan_in  = rd_data_ff.fan_in;
                  rsp_in.entry_fan_out = rd_data_ff.fan_out;
               end
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= LIMIT_RESET;
         used_ff       <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         used_ff       <= used_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      src_in_ff   <= src_in_in;
      dst_out_ff  <= dst_out_in;
      sink_raw_ff <= sink_raw_in;
      weight_ff   <= weight_in;
      hit_ff      <= hit_in;
      full_ff     <= full_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_mod_ff  <= div_mod_in;
      div_cnt_ff  <= div_cnt_in;
      si_ff       <= si_in;
      di_ff       <= di_in;
      scan_cnt_ff <= scan_cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      s_found_ff  <= s_found_in;
      d_found_ff  <= d_found_in;
      s_idx_ff    <= s_idx_in;
      d_idx_ff    <= d_idx_in;
      s_data_ff   <= s_data_in;
      d_data_ff   <= d_data_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         neuron_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= neuron_mem[rd_addr];
      end
   end

   `ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= UW'(TABLE_DEPTH))
   `ASSERT_ALWAYS(a_scan_complete, clock, reset, (state_ff != ST_DECIDE) || (scan_cnt_ff == used_ff))
   `ASSERT_NEXT(a_insert_counts, clock, reset, (state_ff == ST_WR_SRC) && !s_found_ff, used_ff == $past(used_ff) + 1'b1)

endmodule

// ===== bench/gene_table_checker.sv =====
// Checker that predicts each response of the gene table builder and compares it field by field.
`timescale 1ns / 1ps

module gene_table_checker #(
   parameter int TABLE_DEPTH       = 64,
   parameter int INPUT_CLASS_SIZE  = 32,
   parameter int OUTPUT_CLASS_SIZE = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [gtn_pkg::OP_W-1:0]   req_tuser,
   input  logic [gtn_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [gtn_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [gtn_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [gtn_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic                       csr_pready,
   output int                         mismatches,
   output int                         outstanding,
   output int                         checked,
   output int                         full_seen
);
   import gtn_pkg::*;

   localparam logic [CSR_AW-1:0] LIMIT_ADDR    = CSR_AW'(4 * REG_LIMIT);
   localparam logic [15:0]       WEIGHT_OFFSET = 16'h8000;

   logic [MOD_W-1:0] internal_limit;
   entry_type        neuron_store [TABLE_DEPTH];
   int               neurons_held;
   rsp_type          awaited_rsp [$];

   function automatic int find_neuron(input logic [KIND_W-1:0] kind, input int index);
      for (int i = 0; i < neurons_held; i++) begin
         if (neuron_store[i].kind == kind && neuron_store[i].index == index) return i;
      end
      return -1;
   endfunction

   function automatic void append_neuron(input logic [KIND_W-1:0] kind, input int index,
                                         input logic [FAN_W-1:0] fan_in,
                                         input logic [FAN_W-1:0] fan_out);
      neuron_store[neurons_held].kind    = kind;
      neuron_store[neurons_held].index   = IDX_W'(index);
      neuron_store[neurons_held].fan_in  = fan_in;
      neuron_store[neurons_held].fan_out = fan_out;
      neurons_held++;
   endfunction

   function automatic rsp_type apply_table_request(input logic [OP_W-1:0] op,
                                                   input req_type r);
      rsp_type          res;
      int               lim, src_mod, dst_mod, src_idx, dst_idx, src_slot, dst_slot, need;
      logic [KIND_W-1:0] src_kind, dst_kind;
      res = '0;
      case (op)
         OP_CLEAR: begin
            neurons_held = 0;
         end
         OP_READ: begin
            if (int'(r.read_slot) < neurons_held) begin
               res.entry_valid   = 1'b1;
               res.entry_kind    = neuron_store[r.read_slot].kind;
               res.entry_index   = neuron_store[r.read_slot].index;
               res.entry_fan_in  = neuron_store[r.read_slot].fan_in;
               res.entry_fan_out = neuron_store[r.read_slot].fan_out;
            end
         end
         OP_ADD: begin
            lim = (internal_limit == 0) ? 1 : (internal_limit > 256) ? 256 : int'(internal_limit);
            src_kind = r.source_is_input ? KIND_INPUT : KIND_INTERNAL;
            dst_kind = r.sink_is_output ? KIND_OUTPUT : KIND_INTERNAL;
            src_mod  = r.source_is_input ? INPUT_CLASS_SIZE : lim;
            dst_mod  = r.sink_is_output ? OUTPUT_CLASS_SIZE : lim;
            src_idx  = int'(r.source_raw) % src_mod;
            dst_idx  = int'(r.sink_raw) % dst_mod;
            src_slot = find_neuron(src_kind, src_idx);
            dst_slot = find_neuron(dst_kind, dst_idx);
            need = (src_slot < 0) ? 1 : 0;
            if (dst_slot < 0 && !(src_kind == dst_kind && src_idx == dst_idx)) need++;
            res.src_kind    = src_kind;
            res.src_index   = IDX_W'(src_idx);
            res.dst_kind    = dst_kind;
            res.dst_index   = IDX_W'(dst_idx);
            res.link_weight = r.weight_raw ^ WEIGHT_OFFSET;
            if (neurons_held + need > TABLE_DEPTH) begin
               res.table_full = 1'b1;
            end else begin
               if (src_slot < 0) begin
                  append_neuron(src_kind, src_idx, 8'd0, 8'd1);
               end else if (neuron_store[src_slot].fan_out != 8'hFF) begin
                  neuron_store[src_slot].fan_out++;
               end
               dst_slot = find_neuron(dst_kind, dst_idx);
               if (dst_slot < 0) begin
                  append_neuron(dst_kind, dst_idx, 8'd1, 8'd0);
               end else if (neuron_store[dst_slot].fan_in != 8'hFF) begin
                  neuron_store[dst_slot].fan_in++;
               end
            end
         end
         default: ;
      endcase
      res.neuron_total = TOTAL_W'(neurons_held);
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int seen);
      if (want != seen) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      end
   endtask

   initial begin
      mismatches = 0;
      outstanding = 0;
      checked = 0;
      full_seen = 0;
   end

   always @(posedge clock) begin
      rsp_type want_r, seen_r;
      if (reset) begin
         internal_limit = LIMIT_RESET;
         neurons_held = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_r = rsp_tdata;
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: response arrived with no request outstanding", $time);
            end else begin
               want_r = awaited_rsp.pop_front();
               check_field("src_kind", want_r.src_kind, seen_r.src_kind);
               check_field("src_index", want_r.src_index, seen_r.src_index);
               check_field("dst_kind", want_r.dst_kind, seen_r.dst_kind);
               check_field("dst_index", want_r.dst_index, seen_r.dst_index);
               check_field("link_weight", want_r.link_weight, seen_r.link_weight);
               check_field("entry_valid", want_r.entry_valid, seen_r.entry_valid);
               check_field("entry_kind", want_r.entry_kind, seen_r.entry_kind);
               check_field("entry_index", want_r.entry_index, seen_r.entry_index);
               check_field("entry_fan_in", want_r.entry_fan_in, seen_r.entry_fan_in);
               check_field("entry_fan_out", want_r.entry_fan_out, seen_r.entry_fan_out);
               check_field("neuron_total", want_r.neuron_total, seen_r.neuron_total);
               check_field("table_full", want_r.table_full, seen_r.table_full);
               check_field("pad", 0, seen_r.pad);
               if (want_r.table_full) full_seen++;
               checked++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == LIMIT_ADDR)
            internal_limit = csr_pwdata[MOD_W-1:0];
         if (req_tvalid && req_tready)
            awaited_rsp.push_back(apply_table_request(req_tuser, req_type'(req_tdata)));
      end
      outstanding = awaited_rsp.size();
   end

endmodule

// ===== bench/gene_to_neuron_table_builder_tb.sv =====
// Testbench top for the gene table builder: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module gene_to_neuron_table_builder_tb;
   import gtn_pkg::*;

   localparam int TABLE_DEPTH       = 64;
   localparam int INPUT_CLASS_SIZE  = 32;
   localparam int OUTPUT_CLASS_SIZE = 32;
   localparam logic [CSR_AW-1:0] LIMIT_ADDR = CSR_AW'(4 * REG_LIMIT);

   logic               clock;
   logic               reset;
   logic [OP_W-1:0]    req_tuser;
   logic [REQ_W-1:0]   req_tdata;
   logic               req_tvalid;
   logic               req_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [CSR_AW-1:0]  csr_paddr;
   logic [CSR_DW-1:0]  csr_pwdata;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   int mismatches, outstanding, checked, full_seen;
   int idle_pct = 25;
   int sent = 0;
   int limits_set = 0;

   gene_to_neuron_table_builder #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .INPUT_CLASS_SIZE(INPUT_CLASS_SIZE),
      .OUTPUT_CLASS_SIZE(OUTPUT_CLASS_SIZE)
   ) dut (
      .clock(clock), .reset(reset),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   gene_table_checker #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .INPUT_CLASS_SIZE(INPUT_CLASS_SIZE),
      .OUTPUT_CLASS_SIZE(OUTPUT_CLASS_SIZE)
   ) table_check (
      .clock(clock), .reset(reset),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .mismatches(mismatches), .outstanding(outstanding),
      .checked(checked), .full_seen(full_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         rsp_tready <= 1'b1;
         @(negedge clock);
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
      end
   end

   function automatic logic [RAW_W-1:0] random_raw();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return RAW_W'($urandom_range(0, 600));
         default: return RAW_W'($urandom);
      endcase
   endfunction

   function automatic req_type make_gene(input logic src_in, input logic [RAW_W-1:0] src_raw,
                                         input logic snk_out, input logic [RAW_W-1:0] snk_raw,
                                         input logic [RAW_W-1:0] weight,
                                         input logic [SLOT_W-1:0] slot);
      req_type r;
      r.source_is_input = src_in;
      r.source_raw      = src_raw;
      r.sink_is_output  = snk_out;
      r.sink_raw        = snk_raw;
      r.weight_raw      = weight;
      r.read_slot       = slot;
      return r;
   endfunction

   function automatic req_type random_gene(input int internal_pct);
      return make_gene($urandom_range(0, 99) >= internal_pct, random_raw(),
                       $urandom_range(0, 99) >= internal_pct, random_raw(), random_raw(),
                       $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 63))
                                            : SLOT_W'($urandom_range(0, 7)));
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input req_type r);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= r;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [MOD_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= CSR_DW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      limits_set++;
   endtask

   task automatic run_phase(input logic [MOD_W-1:0] limit, input int count,
                            input int internal_pct, input int add_pct,
                            input bit fill, input bit clears, input int idle);
      int roll;
      logic [OP_W-1:0] op;
      drain();
      write_limit(limit);
      idle_pct = idle;
      send_request(OP_CLEAR, random_gene(50));
      // Fill the table with every input and output neuron so that later genes hit a full table.
      if (fill) begin
         for (int i = 0; i < INPUT_CLASS_SIZE; i++)
            send_request(OP_ADD, make_gene(1'b1, {11'($urandom_range(0, 2047)), 5'(i)},
                                           1'b1, {11'($urandom_range(0, 2047)), 5'(i)},
                                           random_raw(), SLOT_W'($urandom_range(0, 63))));
      end
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < add_pct) op = OP_ADD;
         else if (roll < 98) op = OP_READ;
         else if (roll == 98 || !clears) op = OP_NOP;
         else op = OP_CLEAR;
         send_request(op, random_gene(internal_pct));
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tuser   = '0;
      req_tdata   = '0;
      req_tvalid  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reads of an empty table, then genes at the extremes, a self loop and repeated ends.
      send_request(OP_READ, make_gene(1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 6'd0));
      send_request(OP_READ, make_gene(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 6'd63));
      send_request(OP_NOP, make_gene(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 6'd63));
      send_request(OP_ADD, make_gene(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 16'h0000, 6'd0));
      send_request(OP_ADD, make_gene(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 6'd63));
      send_request(OP_ADD, make_gene(1'b0, 16'h0000, 1'b0, 16'h0008, 16'h8000, 6'd0));
      send_request(OP_ADD, make_gene(1'b0, 16'hFFFF, 1'b1, 16'h0000, 16'h7FFF, 6'd0));
      send_request(OP_ADD, make_gene(1'b1, 16'h0000, 1'b0, 16'h0007, 16'h0001, 6'd0));
      for (int s = 0; s < 7; s++)
         send_request(OP_READ, make_gene(1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 6'(s)));
      send_request(OP_CLEAR, make_gene(1'b1, 16'h0000, 1'b1, 16'h0000, 16'h0000, 6'd0));
      send_request(OP_READ, make_gene(1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 6'd0));
      send_request(OP_ADD, make_gene(1'b1, 16'h0000, 1'b1, 16'h0000, 16'h0001, 6'd0));
      send_request(OP_READ, make_gene(1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 6'd1));

      run_phase(9'd256, 100, 60, 75, 1'b1, 1'b1, 30);
      run_phase(9'd0, 300, 98, 92, 1'b0, 1'b0, 0);
      run_phase(9'd511, 70, 50, 75, 1'b0, 1'b1, 40);
      run_phase(MOD_W'($urandom_range(2, 255)), 90, 50, 75, 1'b0, 1'b1, 20);
      run_phase(9'd1, 50, 50, 75, 1'b0, 1'b1, 30);
      run_phase(LIMIT_RESET, 50, 50, 75, 1'b0, 1'b1, 0);

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d requests over %0d internal limit settings; %0d responses checked.",
               sent, limits_set, checked);
      $display("%0d responses reported a full table.", full_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
